@@ rtl/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, status codes and constants for the direct-mapped cache lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // fixed field widths
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 64;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // line memory clearing sequencer states
  typedef enum logic {
    INIT_CLEAR,
    INIT_DONE
  } init_state_t;

  // clearing sequencer status toward the top level
  typedef struct packed {
    logic active;
    logic wr_en;
  } init_ctl_t;

  // backing store contents: byte i holds (i + 1) mod 256
  function automatic logic [DATA_W-1:0] store_byte(input logic [ADDR_W-1:0] addr);
    return addr[DATA_W-1:0] + DATA_W'(1);
  endfunction

endpackage

@@ rtl/dmc_ram.sv @@
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/dmc_init.sv @@
// ----------------------------------------------------------------------------
// dmc_init
// Post-reset sweep that writes every line of the line memory as invalid.
// ----------------------------------------------------------------------------
module dmc_init #(
  parameter int INDEX_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output dmc_pkg::init_ctl_t      ctl,
  output logic [INDEX_BITS-1:0]   clr_index
);

  import dmc_pkg::*;

  init_state_t           state_r;
  init_state_t           state_nxt;
  logic [INDEX_BITS-1:0] idx_r;
  logic [INDEX_BITS-1:0] idx_nxt;
  logic                  last_line;

  assign last_line = (idx_r == {INDEX_BITS{1'b1}});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      INIT_CLEAR: begin
        if (last_line) begin
          state_nxt = INIT_DONE;
        end
      end
      INIT_DONE: begin
        state_nxt = INIT_DONE;
      end
      default: begin
        state_nxt = INIT_CLEAR;
      end
    endcase
  end

  // outputs and sweep index
  always_comb begin
    ctl     = '0;
    idx_nxt = idx_r;
    unique case (state_r)
      INIT_CLEAR: begin
        ctl.active = 1'b1;
        ctl.wr_en  = 1'b1;
        idx_nxt    = idx_r + INDEX_BITS'(1);
      end
      INIT_DONE: begin
        ctl = '0;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= INIT_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign clr_index = idx_r;

endmodule

@@ rtl/dmc_lookup.sv @@
// ----------------------------------------------------------------------------
// dmc_lookup
// Two-stage lookup pipeline: read the line, compare the tag, fill on a miss,
// count and register the result.
// ----------------------------------------------------------------------------
module dmc_lookup #(
  parameter int INDEX_BITS  = 10,
  parameter int TAG_BITS    = 3,
  parameter int STORE_DEPTH = 8192,
  parameter int ENTRY_W     = 1 + TAG_BITS + 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [dmc_pkg::ADDR_W-1:0]    address,
  output logic [INDEX_BITS-1:0]         rd_index,
  input  logic [ENTRY_W-1:0]            rd_entry,
  output logic                          wr_en,
  output logic [INDEX_BITS-1:0]         wr_index,
  output logic [ENTRY_W-1:0]            wr_entry,
  output logic                          res_strobe,
  output dmc_pkg::status_t              res_status,
  output logic [dmc_pkg::DATA_W-1:0]    res_data,
  output logic [dmc_pkg::COUNT_W-1:0]   access_total,
  output logic [dmc_pkg::COUNT_W-1:0]   hit_total,
  output logic [dmc_pkg::COUNT_W-1:0]   miss_total
);

  import dmc_pkg::*;

  localparam int CMP_W = ADDR_W + 1;

  // request decode
  logic [ADDR_W-1:0]   addr_hi;
  logic [TAG_BITS-1:0] req_tag;
  logic                req_range;

  // stage 1 registers
  logic                  s1_valid_r;
  logic [INDEX_BITS-1:0] s1_index_r;
  logic [TAG_BITS-1:0]   s1_tag_r;
  logic                  s1_range_r;
  logic [DATA_W-1:0]     s1_fill_r;

  // last fill, forwarded to a read issued on the same edge
  logic                  fwd_valid_r;
  logic [INDEX_BITS-1:0] fwd_index_r;
  logic [ENTRY_W-1:0]    fwd_entry_r;

  // stage 1 logic
  logic [ENTRY_W-1:0]  entry;
  logic                line_valid;
  logic [TAG_BITS-1:0] line_tag;
  logic [DATA_W-1:0]   line_data;
  logic                hit;
  logic                counted;

  // counters and result registers
  logic [COUNT_W-1:0] access_r, access_nxt;
  logic [COUNT_W-1:0] hit_r, hit_nxt;
  logic [COUNT_W-1:0] miss_r, miss_nxt;
  logic               strobe_r;
  status_t            status_r, status_nxt;
  logic [DATA_W-1:0]  data_r, data_nxt;

  // address split and range check
  assign addr_hi   = address >> INDEX_BITS;
  assign req_tag   = addr_hi[TAG_BITS-1:0];
  assign req_range = ({1'b0, address} >= CMP_W'(STORE_DEPTH));
  assign rd_index  = address[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index_r <= address[INDEX_BITS-1:0];
      s1_tag_r   <= req_tag;
      s1_range_r <= req_range;
      s1_fill_r  <= store_byte(address);
    end
  end

  // pick the forwarded line when the previous fill hit the same index
  assign entry = (fwd_valid_r && (fwd_index_r == s1_index_r)) ? fwd_entry_r : rd_entry;
  assign line_valid = entry[ENTRY_W-1];
  assign line_tag   = entry[ENTRY_W-2 -: TAG_BITS];
  assign line_data  = entry[DATA_W-1:0];
  assign hit        = line_valid && (line_tag == s1_tag_r);
  assign counted    = s1_valid_r && !s1_range_r;

  // fill on a miss
  assign wr_en    = counted && !hit;
  assign wr_index = s1_index_r;
  assign wr_entry = {1'b1, s1_tag_r, s1_fill_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_index_r <= wr_index;
      fwd_entry_r <= wr_entry;
    end
  end

  // counter update and result decode
  always_comb begin
    access_nxt = access_r;
    hit_nxt    = hit_r;
    miss_nxt   = miss_r;
    status_nxt = ST_RANGE;
    data_nxt   = '0;
    if (counted) begin
      access_nxt = access_r + COUNT_W'(1);
      if (hit) begin
        hit_nxt    = hit_r + COUNT_W'(1);
        status_nxt = ST_HIT;
        data_nxt   = line_data;
      end else begin
        miss_nxt   = miss_r + COUNT_W'(1);
        status_nxt = ST_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_r <= '0;
      hit_r    <= '0;
      miss_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      access_r <= access_nxt;
      hit_r    <= hit_nxt;
      miss_r   <= miss_nxt;
      strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  assign res_strobe   = strobe_r;
  assign res_status   = status_r;
  assign res_data     = data_r;
  assign access_total = access_r;
  assign hit_total    = hit_r;
  assign miss_total   = miss_r;

endmodule

@@ rtl/direct_mapped_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup
// Direct-mapped read cache in front of a byte backing store, with counters.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it sweeps the 2**INDEX_BITS
// lines of the line memory (1024 by default) and marks every line invalid.
// From then on busy stays low and one address can be taken in every cycle.
// Each transaction gives exactly one result, which passes through the line
// memory's registered read, then the tag compare and the result register,
// and is shown for one cycle under out_strobe; the receiver cannot hold
// results off. A fill written by one transaction is forwarded to the next,
// so back-to-back reads of one line are coherent.
// The counters on the result ports already include the transaction shown.
module direct_mapped_cache_lookup #(
  parameter int INDEX_BITS  = 10,
  parameter int STORE_DEPTH = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dmc_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_strobe,
  output dmc_pkg::status_t              out_status,
  output logic [dmc_pkg::DATA_W-1:0]    out_read_data,
  output logic [dmc_pkg::COUNT_W-1:0]   out_access_count,
  output logic [dmc_pkg::COUNT_W-1:0]   out_hit_count,
  output logic [dmc_pkg::COUNT_W-1:0]   out_miss_count
);

  import dmc_pkg::*;

  localparam int LINES    = 1 << INDEX_BITS;
  localparam int ADDR_BITS = $clog2(STORE_DEPTH);
  localparam int TAG_BITS = (ADDR_BITS > INDEX_BITS) ? (ADDR_BITS - INDEX_BITS) : 1;
  localparam int ENTRY_W  = 1 + TAG_BITS + DATA_W;

  init_ctl_t             init_ctl;
  logic [INDEX_BITS-1:0] clr_index;
  logic                  accept;
  logic [INDEX_BITS-1:0] rd_index;
  logic [ENTRY_W-1:0]    rd_entry;
  logic                  lk_wr_en;
  logic [INDEX_BITS-1:0] lk_wr_index;
  logic [ENTRY_W-1:0]    lk_wr_entry;
  logic                  ram_wr_en;
  logic [INDEX_BITS-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0]    ram_wr_data;

  // clearing pass after reset
  dmc_init #(
    .INDEX_BITS(INDEX_BITS)
  ) u_init (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (init_ctl),
    .clr_index(clr_index)
  );

  assign busy   = init_ctl.active;
  assign accept = start && !busy;

  // lookup pipeline
  dmc_lookup #(
    .INDEX_BITS (INDEX_BITS),
    .TAG_BITS   (TAG_BITS),
    .STORE_DEPTH(STORE_DEPTH),
    .ENTRY_W    (ENTRY_W)
  ) u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .address     (in_address),
    .rd_index    (rd_index),
    .rd_entry    (rd_entry),
    .wr_en       (lk_wr_en),
    .wr_index    (lk_wr_index),
    .wr_entry    (lk_wr_entry),
    .res_strobe  (out_strobe),
    .res_status  (out_status),
    .res_data    (out_read_data),
    .access_total(out_access_count),
    .hit_total   (out_hit_count),
    .miss_total  (out_miss_count)
  );

  // write port: sweep during the clearing pass, fills afterwards
  always_comb begin
    if (init_ctl.wr_en) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_index;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = lk_wr_en;
      ram_wr_addr = lk_wr_index;
      ram_wr_data = lk_wr_entry;
    end
  end

  // line memory: valid, tag and data per line
  dmc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LINES)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(rd_index),
    .rd_data(rd_entry)
  );

endmodule

@@ rtl/dmc_checker.sv @@
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks for the direct-mapped cache lookup, bound to the top.
// ----------------------------------------------------------------------------
module dmc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input dmc_pkg::status_t              out_status,
  input logic [dmc_pkg::DATA_W-1:0]    out_read_data,
  input logic [dmc_pkg::COUNT_W-1:0]   out_access_count,
  input logic [dmc_pkg::COUNT_W-1:0]   out_hit_count,
  input logic [dmc_pkg::COUNT_W-1:0]   out_miss_count
);

  import dmc_pkg::*;

  // every taken transaction gives a result on out_strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("transaction without a result");

  // accesses are always split into hits and misses
  a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_access_count == out_hit_count + out_miss_count)
    else $error("access count differs from hits plus misses");

  // a hit advances the hit counter by one
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_HIT) |-> out_hit_count == $past(out_hit_count) + 64'd1)
    else $error("hit counter did not advance on a hit");

  // only a hit returns data
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_HIT) |-> out_read_data == '0)
    else $error("nonzero data on a miss or out-of-range result");

  // the access counter moves only with a result
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> $stable(out_access_count))
    else $error("access counter moved without a result");

endmodule

bind direct_mapped_cache_lookup dmc_checker u_dmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_read_data   (out_read_data),
  .out_access_count(out_access_count),
  .out_hit_count   (out_hit_count),
  .out_miss_count  (out_miss_count)
);

@@ dv/tb_direct_mapped_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_lookup
// Self-checking bench for the direct-mapped cache lookup. A scoreboard keeps
// its own copy of the line valid, tag and data stores and of the three
// counters. It predicts status, data and counts for every address the block
// takes, and compares each strobed result against the oldest prediction.
// Stimulus is a directed set of hit, miss, conflict and out-of-range cases,
// followed by random traffic that mostly revisits a few hot lines.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  localparam int INDEX_BITS   = 10;
  localparam int STORE_DEPTH  = 8192;
  localparam int LINES        = 1 << INDEX_BITS;
  localparam int HOT_LINES    = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_REPORTED = 10;

  // one predicted lookup result
  typedef struct {
    status_t              status;
    logic [DATA_W-1:0]    data;
    logic [COUNT_W-1:0]   accesses;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
  } lookup_result_t;

  // cache predictor and result checker
  class cache_lookup_scoreboard;
    bit                 line_valid [LINES];
    logic [ADDR_W-1:0]  line_tag   [LINES];
    logic [DATA_W-1:0]  line_data  [LINES];
    logic [COUNT_W-1:0] access_total = '0;
    logic [COUNT_W-1:0] hit_total    = '0;
    logic [COUNT_W-1:0] miss_total   = '0;
    lookup_result_t     pending_lookups [$];
    int                 fail_count = 0;

    function void log_failure(string msg);
      if (fail_count < MAX_REPORTED) begin
        $display("%t: %s", $realtime, msg);
      end
      fail_count++;
    endfunction

    // predict the outcome of one accepted address
    function void note_address(logic [ADDR_W-1:0] addr);
      lookup_result_t    res;
      int                idx;
      logic [ADDR_W-1:0] tag;
      res.status = ST_RANGE;
      res.data   = '0;
      if (addr < STORE_DEPTH) begin
        idx = addr % LINES;
        tag = addr / LINES;
        access_total++;
        if (line_valid[idx] && line_tag[idx] == tag) begin
          hit_total++;
          res.data   = line_data[idx];
          res.status = ST_HIT;
        end else begin
          // fill from the store, which holds address plus one
          miss_total++;
          line_data[idx]  = DATA_W'(addr + 1);
          line_tag[idx]   = tag;
          line_valid[idx] = 1'b1;
          res.status      = ST_MISS;
        end
      end
      res.accesses = access_total;
      res.hits     = hit_total;
      res.misses   = miss_total;
      pending_lookups.push_back(res);
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_lookup(status_t st, logic [DATA_W-1:0] data,
                               logic [COUNT_W-1:0] acc, logic [COUNT_W-1:0] hit,
                               logic [COUNT_W-1:0] miss);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        log_failure($sformatf("result with no transaction pending: status %0d", st));
        return;
      end
      want = pending_lookups.pop_front();
      if (st !== want.status)
        log_failure($sformatf("status: expected %0d, got %0d", want.status, st));
      if (data !== want.data)
        log_failure($sformatf("read_data: expected %h, got %h", want.data, data));
      if (acc !== want.accesses)
        log_failure($sformatf("access_count: expected %0d, got %0d", want.accesses, acc));
      if (hit !== want.hits)
        log_failure($sformatf("hit_count: expected %0d, got %0d", want.hits, hit));
      if (miss !== want.misses)
        log_failure($sformatf("miss_count: expected %0d, got %0d", want.misses, miss));
    endfunction

    function void check_drained();
      if (pending_lookups.size() != 0)
        log_failure($sformatf("%0d transactions never answered", pending_lookups.size()));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ADDR_W-1:0]  in_address;
  logic               out_strobe;
  status_t            out_status;
  logic [DATA_W-1:0]  out_read_data;
  logic [COUNT_W-1:0] out_access_count;
  logic [COUNT_W-1:0] out_hit_count;
  logic [COUNT_W-1:0] out_miss_count;

  cache_lookup_scoreboard sb = new();

  direct_mapped_cache_lookup #(
    .INDEX_BITS (INDEX_BITS),
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_address      (in_address),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_access_count(out_access_count),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count)
  );

  always #5ns clk = ~clk;

  // monitor: results first, then the transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_lookup(out_status, out_read_data, out_access_count,
                        out_hit_count, out_miss_count);
      if (start && !busy)
        sb.note_address(in_address);
    end
  end

  // present one address and hold it until the block takes it
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    start      = 1'b1;
    in_address = addr;
    do @(posedge clk); while (busy);
  endtask

  // start low, address noise
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start      = 1'b0;
      in_address = ADDR_W'($urandom);
    end
  endtask

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly hot lines with random tags, so hits and conflicts are frequent
  function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] prev);
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 10) return prev;
    if (r < 65) begin
      idx = ($urandom_range(0, HOT_LINES - 1) * 67) % LINES;
      return ADDR_W'($urandom_range(0, STORE_DEPTH / LINES - 1) * LINES + idx);
    end
    if (r < 85) return ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
    return ADDR_W'($urandom_range(0, 65535));
  endfunction

  // stimulus
  initial begin
    logic [ADDR_W-1:0] directed [$];
    logic [ADDR_W-1:0] prev;
    logic [ADDR_W-1:0] addr;
    start      = 1'b0;
    in_address = '0;
    rst_n      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // cold miss then hit, top line, eviction, last in-range byte, out of range,
    // alternating bit patterns, and a same-line conflict back to back
    directed = '{16'h0000, 16'h0000, 16'h03FF, 16'h03FF, 16'h0400, 16'h0000,
                 16'h0000, 16'h1FFF, 16'h1FFF, 16'h1C00, 16'h2000, 16'hFFFF,
                 16'hAAAA, 16'h5555, 16'h1555, 16'h0AAA, 16'h1555, 16'h0AAA,
                 16'h1FFF, 16'h0005, 16'h0405, 16'h0005};
    foreach (directed[i]) send_address(directed[i]);

    // random traffic, with stretches of back-to-back transactions
    prev = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ((i / 128) % 3 != 0) idle_cycles(pick_gap());
      addr = pick_address(prev);
      send_address(addr);
      prev = addr;
    end
    idle_cycles(1);

    // drain, then allow for the pipeline latency
    for (int w = 0; w < 1000 && sb.pending_lookups.size() > 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();

    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/dmc_init.sv
rtl/dmc_lookup.sv
rtl/direct_mapped_cache_lookup.sv
rtl/dmc_checker.sv
dv/tb_direct_mapped_cache_lookup.sv
